// ===== hdl/parse_integer_radix_core_defines.svh =====
// Assertion helpers for the integer parser.
// PIR_ASSERT is checked outside reset, PIR_ASSERT_ALWAYS on every clock edge.
`ifndef PARSE_INTEGER_RADIX_CORE_DEFINES_SVH
`define PARSE_INTEGER_RADIX_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PIR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PIR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIR_ASSERT(lbl, prop, msg)
`define PIR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/pir_pkg.sv =====
package pir_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [5:0] RADIX_DEFAULT = 6'd10;
	localparam logic [5:0] RADIX_HEX     = 6'd16;
	localparam logic [5:0] RADIX_MIN     = 6'd2;
	localparam logic [5:0] RADIX_MAX     = 6'd36;
	localparam logic [5:0] DIGIT_NONE    = 6'd63;
	localparam logic [7:0] DIGIT_LETTER0 = 8'd10;

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	typedef struct packed {
		logic [7:0] ch;
		logic [5:0] radix_in;
		logic       no_char;
		logic       last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               is_nan;
	} result_t;

	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_MINUS,
		CLS_PLUS,
		CLS_ZERO,
		CLS_XLET,
		CLS_OTHER
	} cls_t;

	typedef enum logic [1:0] {
		PH_SPACE,
		PH_SIGN,
		PH_DIGIT,
		PH_STOP
	} phase_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_SIGN,
		ACT_ZERO,
		ACT_HEX,
		ACT_DIGIT,
		ACT_STOP
	} act_t;

	// Classified word passed from the front to the back through the queue.
	typedef struct packed {
		logic       first;
		logic       last;
		logic       no_char;
		cls_t       cls;
		logic [5:0] digit;
		logic [5:0] radix;
		logic       prefix_ok;
		logic       radix_bad;
	} tok_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [5:0] digit_of(input logic [7:0] ch);
		logic [5:0] d;
		d = DIGIT_NONE;
		if (ch >= CH_0 && ch <= CH_9) begin
			d = 6'(ch - CH_0);
		end else if (ch >= CH_LA && ch <= CH_LZ) begin
			d = 6'(ch - CH_LA + DIGIT_LETTER0);
		end else if (ch >= CH_UA && ch <= CH_UZ) begin
			d = 6'(ch - CH_UA + DIGIT_LETTER0);
		end
		return d;
	endfunction

	function automatic cls_t classify(input logic [7:0] ch);
		cls_t c;
		unique case (ch) inside
			CH_SP, CH_TAB, CH_LF, CH_CR: c = CLS_SPACE;
			CH_MINUS:                    c = CLS_MINUS;
			CH_PLUS:                     c = CLS_PLUS;
			CH_0:                        c = CLS_ZERO;
			CH_LX, CH_UX:                c = CLS_XLET;
			default:                     c = CLS_OTHER;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/parse_integer_radix_core.sv =====
// Channel  | Direction | Handshake                  | Word
// item     | in        | item_valid / item_stall     | item_t: ch, radix_in, no_char, last
// result   | out       | result_valid / result_stall | result_t: value, is_nan
//
// One byte is taken per clock while the queue is not full; the back end does one multiply-add per byte.
// A result is valid from the edge that pops its closing word from the two-entry queue,
// after that word has been written into the queue and has reached its head.
// Reset clears all control state and the queue, and the next word starts a string.
// A stalled result blocks only closing words; other bytes keep flowing until the queue fills.
`include "parse_integer_radix_core_defines.svh"

module parse_integer_radix_core import pir_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	q_status_t q_status;
	logic      push;
	logic      pop;
	tok_t      push_tok;
	tok_t      q_head;

	pir_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.tok        (push_tok)
	);

	pir_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.pop      (pop),
		.head     (q_head),
		.status   (q_status)
	);

	pir_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`PIR_ASSERT(a_queue_sane, !(q_status.full && q_status.empty), "queue full and empty")
	`PIR_ASSERT(a_pop_nonempty, pop |-> !q_status.empty, "pop from empty queue")
	`PIR_ASSERT(a_close_gives_result, pop && q_head.last |=> result_valid, "closing word lost")
	`PIR_ASSERT(a_nan_zero, result_valid && result.is_nan |-> result.value == 0, "NaN value not zero")

endmodule

// ===== hdl/pir_front.sv =====
module pir_front import pir_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  item_t     item,
	input  q_status_t q_status,
	output logic      push,
	output tok_t      tok
);

	logic in_string_q;

	assign item_stall = q_status.full;
	assign push       = item_valid && !q_status.full;

	always_comb begin
		tok.first     = !in_string_q;
		tok.last      = item.last;
		tok.no_char   = item.no_char;
		tok.cls       = classify(item.ch);
		tok.digit     = digit_of(item.ch);
		if (item.radix_in == '0) begin
			tok.radix     = RADIX_DEFAULT;
			tok.prefix_ok = 1'b1;
			tok.radix_bad = 1'b0;
		end else begin
			tok.radix     = item.radix_in;
			tok.prefix_ok = (item.radix_in == RADIX_HEX);
			tok.radix_bad = (item.radix_in < RADIX_MIN) || (item.radix_in > RADIX_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q <= 1'b0;
		end else if (push) begin
			in_string_q <= !item.last;
		end
	end

endmodule

// ===== hdl/pir_queue.sv =====
module pir_queue import pir_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tok_t      push_tok,
	input  logic      pop,
	output tok_t      head,
	output q_status_t status
);

	tok_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

// ===== hdl/pir_back.sv =====
module pir_back import pir_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tok_t      head,
	input  q_status_t q_status,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_stall,
	output result_t   result
);

	phase_t                 phase_q, phase_e, phase_n;
	logic                   neg_q, neg_e, neg_n;
	logic [5:0]             radix_q, radix_e, radix_n;
	logic                   pfx_ok_q, pfx_ok_e;
	logic                   pend_q, pend_e, pend_n;
	logic                   has_q, has_e, has_n;
	logic                   bad_q, bad_e;
	logic [VALUE_WIDTH-1:0] acc_q, acc_e, acc_n;
	logic [VALUE_WIDTH+5:0] mac;
	logic [VALUE_WIDTH-1:0] signed_v;
	logic [VALUE_WIDTH+31:0] ext_v;
	act_t                   act;
	act_t                   take_act;
	logic                   out_free;
	logic                   result_valid_q;
	result_t                result_q;
	result_t                result_n;

	assign out_free = !result_valid_q || !result_stall;
	// A word that closes a string needs the output register free.
	assign pop      = !q_status.empty && (!head.last || out_free);

	// The first word of a string starts from fresh state.
	always_comb begin
		if (head.first) begin
			phase_e  = PH_SPACE;
			neg_e    = 1'b0;
			radix_e  = head.radix;
			pfx_ok_e = head.prefix_ok;
			pend_e   = 1'b0;
			has_e    = 1'b0;
			bad_e    = head.radix_bad;
			acc_e    = '0;
		end else begin
			phase_e  = phase_q;
			neg_e    = neg_q;
			radix_e  = radix_q;
			pfx_ok_e = pfx_ok_q;
			pend_e   = pend_q;
			has_e    = has_q;
			bad_e    = bad_q;
			acc_e    = acc_q;
		end
	end

	// Decode what this byte does in the current phase.
	always_comb begin
		take_act = (head.digit < radix_e) ? ACT_DIGIT : ACT_STOP;
		act      = ACT_NONE;
		if (!head.no_char) begin
			unique case (phase_e)
				PH_SPACE: begin
					if (head.cls == CLS_SPACE) begin
						act = ACT_NONE;
					end else if (head.cls == CLS_MINUS || head.cls == CLS_PLUS) begin
						act = ACT_SIGN;
					end else if (pfx_ok_e && head.cls == CLS_ZERO) begin
						act = ACT_ZERO;
					end else begin
						act = take_act;
					end
				end
				PH_SIGN: begin
					if (pfx_ok_e && head.cls == CLS_ZERO) begin
						act = ACT_ZERO;
					end else begin
						act = take_act;
					end
				end
				PH_DIGIT: begin
					if (pend_e && head.cls == CLS_XLET) begin
						act = ACT_HEX;
					end else begin
						act = take_act;
					end
				end
				PH_STOP: act = ACT_NONE;
				default: act = ACT_NONE;
			endcase
		end
	end

	always_comb begin
		phase_n = phase_e;
		unique case (act)
			ACT_SIGN:                     phase_n = PH_SIGN;
			ACT_ZERO, ACT_HEX, ACT_DIGIT: phase_n = PH_DIGIT;
			ACT_STOP:                     phase_n = PH_STOP;
			ACT_NONE:                     phase_n = phase_e;
			default:                      phase_n = phase_e;
		endcase
		if (head.last) begin
			phase_n = PH_SPACE;
		end
	end

	assign mac = {6'b0, acc_e} * {{VALUE_WIDTH{1'b0}}, radix_e}
		+ {{VALUE_WIDTH{1'b0}}, head.digit};

	always_comb begin
		neg_n   = neg_e;
		radix_n = radix_e;
		has_n   = has_e;
		acc_n   = acc_e;
		pend_n  = (act == ACT_NONE) ? pend_e : 1'b0;
		case (act)
			ACT_SIGN:  neg_n = (head.cls == CLS_MINUS);
			ACT_ZERO: begin
				pend_n = 1'b1;
				has_n  = 1'b1;
				acc_n  = '0;
			end
			ACT_HEX: begin
				has_n   = 1'b0;
				radix_n = RADIX_HEX;
			end
			ACT_DIGIT: begin
				has_n = 1'b1;
				acc_n = mac[VALUE_WIDTH-1:0];
			end
			default: ;
		endcase
		if (head.last) begin
			pend_n = 1'b0;
		end

		signed_v        = neg_n ? ('0 - acc_n) : acc_n;
		ext_v           = {32'b0, signed_v};
		result_n.is_nan = bad_e || !has_n;
		result_n.value  = result_n.is_nan ? '0 : $signed(ext_v[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SPACE;
			neg_q    <= 1'b0;
			radix_q  <= RADIX_DEFAULT;
			pfx_ok_q <= 1'b1;
			pend_q   <= 1'b0;
			has_q    <= 1'b0;
			bad_q    <= 1'b0;
			acc_q    <= '0;
		end else if (pop) begin
			phase_q  <= phase_n;
			neg_q    <= neg_n;
			radix_q  <= radix_n;
			pfx_ok_q <= pfx_ok_e;
			pend_q   <= pend_n;
			has_q    <= has_n;
			bad_q    <= bad_e;
			acc_q    <= acc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			result_q <= result_n;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== test/tb_parse_integer_radix_core.sv =====
`timescale 1ns / 1ps

module tb_parse_integer_radix_core;
	import pir_pkg::*;

	localparam int BUSY_PCT     = 31;
	localparam int RANDOM_WORDS = 1350;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_REPORTS  = 10;
	localparam logic [5:0] RADIX_AUTO = 6'd0;
	localparam logic [7:0] SPACES [4] = '{CH_SP, CH_TAB, CH_LF, CH_CR};

	// Bit 8 of an entry marks a word that carries no byte.
	typedef logic [8:0] text_t[$];

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int idle_pct = BUSY_PCT;
	int stall_pct = BUSY_PCT;
	int words_sent = 0;
	int error_count = 0;
	int cycle_count = 0;

	result_t pending_results[$];

	// Shadow of the parser state.
	logic        in_str = 1'b0;
	phase_t      ph = PH_SPACE;
	logic        neg = 1'b0;
	logic [5:0]  rad = RADIX_DEFAULT;
	logic        pfx_ok = 1'b1;
	logic        pfx_pend = 1'b0;
	logic        got_digit = 1'b0;
	logic        bad_rad = 1'b0;
	logic [31:0] acc = '0;

	parse_integer_radix_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL parse_integer_radix_core");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic int digit_value(input logic [7:0] c);
		if (c inside {[CH_0:CH_9]}) return int'(c - CH_0);
		if (c inside {[CH_LA:CH_LZ]}) return int'(c - CH_LA) + 10;
		if (c inside {[CH_UA:CH_UZ]}) return int'(c - CH_UA) + 10;
		return 99;
	endfunction

	function automatic logic [7:0] digit_char(input int d);
		if (d < 10) return 8'(CH_0 + d);
		return 8'(($urandom_range(1) ? CH_LA : CH_UA) + d - 10);
	endfunction

	function automatic void report_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
	endfunction

	// Updates the shadow state with one accepted word and queues the parsed
	// integer when the word closes a string.
	function automatic void advance_parse(input item_t w);
		logic [7:0] c;
		logic       open;
		int         d;
		result_t    r;
		c = w.ch;
		if (!in_str) begin
			in_str = 1'b1;
			ph = PH_SPACE;
			neg = 1'b0;
			pfx_pend = 1'b0;
			got_digit = 1'b0;
			acc = '0;
			bad_rad = 1'b0;
			if (w.radix_in == RADIX_AUTO) begin
				rad = RADIX_DEFAULT;
				pfx_ok = 1'b1;
			end else begin
				rad = w.radix_in;
				pfx_ok = (w.radix_in == RADIX_HEX);
				bad_rad = (w.radix_in < RADIX_MIN) || (w.radix_in > RADIX_MAX);
			end
		end
		if (!w.no_char) begin
			// open stays set while the byte has not been used up.
			open = 1'b1;
			if (ph == PH_SPACE) begin
				if (c inside {CH_SP, CH_TAB, CH_LF, CH_CR}) begin
					open = 1'b0;
				end else if (c == CH_MINUS || c == CH_PLUS) begin
					neg = (c == CH_MINUS);
					ph = PH_SIGN;
					open = 1'b0;
				end else begin
					ph = PH_SIGN;
				end
			end
			if (open && ph == PH_SIGN) begin
				ph = PH_DIGIT;
				if (pfx_ok && c == CH_0) begin
					pfx_pend = 1'b1;
					got_digit = 1'b1;
					acc = '0;
					open = 1'b0;
				end
			end else if (open && ph == PH_DIGIT && pfx_pend) begin
				pfx_pend = 1'b0;
				if (c == CH_LX || c == CH_UX) begin
					got_digit = 1'b0;
					rad = RADIX_HEX;
					open = 1'b0;
				end
			end
			if (open && ph == PH_DIGIT) begin
				d = digit_value(c);
				if (d >= int'(rad)) begin
					ph = PH_STOP;
				end else begin
					acc = acc * 32'(rad) + 32'(d);
					got_digit = 1'b1;
				end
			end
		end
		if (w.last) begin
			r.is_nan = bad_rad || !got_digit;
			r.value = r.is_nan ? 32'sd0 : (neg ? 32'(-acc) : acc);
			pending_results.push_back(r);
			in_str = 1'b0;
			ph = PH_SPACE;
			pfx_pend = 1'b0;
		end
	endfunction

	always @(posedge clk) begin : scoreboard
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					report_error($sformatf("unexpected result value=%0d is_nan=%0b",
						result.value, result.is_nan));
				end else begin
					want = pending_results.pop_front();
					if (result.value !== want.value || result.is_nan !== want.is_nan) begin
						report_error($sformatf("value=%0d is_nan=%0b, expected value=%0d is_nan=%0b",
							result.value, result.is_nan, want.value, want.is_nan));
					end
				end
			end
			if (item_valid && !item_stall) advance_parse(item);
		end
	end

	task automatic send_word(input item_t w);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		words_sent++;
	endtask

	// Sends one string; the radix rides on the first word only, later words
	// carry random radix bits that the parser must ignore.
	task automatic send_run(input text_t bytes, input logic [5:0] radix);
		item_t w;
		int    n;
		if (bytes.size() == 0) bytes.push_back({1'b1, 8'($urandom_range(255))});
		n = bytes.size();
		for (int i = 0; i < n; i++) begin
			w.ch = bytes[i][7:0];
			w.no_char = bytes[i][8];
			w.radix_in = (i == 0) ? radix : 6'($urandom_range(63));
			w.last = (i == n - 1);
			send_word(w);
		end
	endtask

	function automatic text_t text_of(input string s);
		text_t t;
		for (int i = 0; i < s.len(); i++) t.push_back({1'b0, 8'(s[i])});
		return t;
	endfunction

	task automatic test_space_and_sign();
		text_t t;
		t = {{1'b0, CH_CR}, {1'b0, CH_LF}};
		t = {t, text_of(" -7")};
		send_run(t, RADIX_AUTO);
		send_run(text_of("+z"), RADIX_MAX);
		send_run(text_of(" "), RADIX_AUTO);
		t.delete();
		send_run(t, RADIX_AUTO);
	endtask

	task automatic test_prefix_and_zero();
		send_run(text_of("0x"), RADIX_AUTO);
		send_run(text_of("0"), RADIX_AUTO);
		send_run(text_of("0XA"), RADIX_HEX);
	endtask

	task automatic test_radix_limits();
		send_run(text_of("9"), 6'd1);
		send_run(text_of("1"), 6'd63);
	endtask

	task automatic test_overflow_and_stop();
		text_t t;
		send_run(text_of("ZZZZZZZ"), RADIX_MAX);
		t = {{1'b0, CH_0 + 8'd1}, 9'h0FF, {1'b0, CH_0}};
		send_run(t, RADIX_MIN);
	endtask

	task automatic test_random_strings();
		text_t      t;
		logic [5:0] radix;
		int         base;
		int         sel;
		int         run_no;
		int         start_count;
		run_no = 0;
		start_count = words_sent;
		while (words_sent - start_count < RANDOM_WORDS) begin
			run_no++;
			if (run_no == 60) begin
				idle_pct = 0;
				stall_pct = 0;
			end else if (run_no == 140) begin
				idle_pct = BUSY_PCT;
				stall_pct = BUSY_PCT;
			end
			sel = $urandom_range(99);
			if (sel < 30) radix = RADIX_AUTO;
			else if (sel < 45) radix = RADIX_HEX;
			else if (sel < 55) radix = RADIX_DEFAULT;
			else if (sel < 92) radix = 6'($urandom_range(2, 36));
			else if (sel < 95) radix = 6'd1;
			else radix = 6'($urandom_range(37, 63));
			base = (radix >= RADIX_MIN && radix <= RADIX_MAX) ? int'(radix) : 10;
			t.delete();
			if ($urandom_range(99) < 85) begin
				repeat ($urandom_range(0, 2)) t.push_back({1'b0, SPACES[$urandom_range(3)]});
				sel = $urandom_range(5);
				if (sel < 2) t.push_back({1'b0, CH_MINUS});
				else if (sel == 2) t.push_back({1'b0, CH_PLUS});
				if ((radix == RADIX_AUTO || radix == RADIX_HEX) && $urandom_range(2) == 0) begin
					t.push_back({1'b0, CH_0});
					if ($urandom_range(3) != 0) begin
						t.push_back({1'b0, $urandom_range(1) ? CH_LX : CH_UX});
						base = 16;
					end
				end else if ($urandom_range(9) == 0) begin
					t.push_back({1'b0, CH_0});
				end
				repeat ($urandom_range(0, 9)) t.push_back({1'b0, digit_char($urandom_range(base - 1))});
				if ($urandom_range(4) == 0) begin
					t.push_back({1'b0, 8'($urandom_range(255))});
					repeat ($urandom_range(0, 3))
						t.push_back({1'b0, digit_char($urandom_range(base - 1))});
				end
				if ($urandom_range(15) == 0)
					t.insert($urandom_range(t.size()), {1'b1, 8'($urandom_range(255))});
				if ($urandom_range(7) == 0) t.push_back({1'b1, 8'($urandom_range(255))});
			end else begin
				radix = 6'($urandom_range(63));
				repeat ($urandom_range(0, 6))
					t.push_back({$urandom_range(7) == 0, 8'($urandom_range(255))});
			end
			send_run(t, radix);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_space_and_sign();
		test_prefix_and_zero();
		test_radix_limits();
		test_overflow_and_stop();
		test_random_strings();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS parse_integer_radix_core");
		end else begin
			$display("FAIL parse_integer_radix_core");
		end
		$finish;
	end

endmodule
